// ----- rtl/core/lad_pkg.sv -----
// shared types and constants for the linear array deque
package lad_pkg;

  localparam int DEPTH_DEFAULT = 8;
  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    MODE_INS_FRONT = 2'd0,
    MODE_INS_REAR  = 2'd1,
    MODE_DEL_FRONT = 2'd2,
    MODE_DEL_REAR  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  typedef struct packed {
    mode_t                     mode;
    logic signed [DATA_W-1:0]  value;
  } req_t;

  typedef struct packed {
    status_t                   status;
    logic signed [DATA_W-1:0]  removed_value;
    logic                      is_empty;
    logic                      is_full;
  } rsp_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic exec;
  } ctl_t;

endpackage

// ----- rtl/core/linear_array_deque_top.sv -----
// an accepted transfer passes through the execute state and then the response state, where the result strobe is high
// one operation at a time: a new transfer is taken only in the idle state; busy covers execute and response cycles
// the execute cycle updates the indices, writes at most one entry and reads one entry
// reset is synchronous and active high: deque empty, both indices zero, busy and done low
// entry contents are not cleared by reset; an entry's value reaches the result only after being written
// the receiver cannot stall: each result is shown for exactly one cycle with done high
module linear_array_deque_top #(
  parameter int DEPTH = lad_pkg::DEPTH_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  lad_pkg::req_t   req,
  output logic            done,
  output lad_pkg::rsp_t   rsp
);
  import lad_pkg::*;

  ctl_t ctl;

  lad_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .ctl   (ctl)
  );

  lad_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk (clk),
    .rst (rst),
    .ctl (ctl),
    .req (req),
    .rsp (rsp)
  );

endmodule

// ----- rtl/core/lad_ctrl.sv -----
// controller state machine sequencing one deque operation at a time
module lad_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  output logic            done,
  output lad_pkg::ctl_t   ctl
);
  import lad_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_EXEC;
            busy  <= 1'b1;
          end
        end
        S_EXEC: begin
          state <= S_RESP;
          done  <= 1'b1;
        end
        S_RESP: begin
          state <= S_IDLE;
          done  <= 1'b0;
          busy  <= 1'b0;
        end
        default: begin
          state <= S_IDLE;
          done  <= 1'b0;
          busy  <= 1'b0;
        end
      endcase
    end
  end

  assign ctl.load = (state == S_IDLE) && start;
  assign ctl.exec = (state == S_EXEC);

  // every accepted transfer raises the result strobe once the execute state has passed
  a_done_after_accept: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> ##1 done)
    else $error("result strobe missing after accepted transfer");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  a_done_while_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy && !ctl.load && !ctl.exec)
    else $error("result strobe outside a busy operation");

endmodule

// ----- rtl/core/lad_dpath.sv -----
// deque datapath: front and rear indices, entry memory and result register
module lad_dpath #(
  parameter int DEPTH = lad_pkg::DEPTH_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  input  lad_pkg::ctl_t   ctl,
  input  lad_pkg::req_t   req,
  output lad_pkg::rsp_t   rsp
);
  import lad_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam logic [IW-1:0] LAST = IW'(DEPTH - 1);

  req_t                cmd;
  logic [IW-1:0]       front;
  logic [IW-1:0]       rear;
  logic                empty;
  logic [IW-1:0]       front_next;
  logic [IW-1:0]       rear_next;
  logic                empty_next;
  status_t             st;
  logic                wr_en;
  logic [IW-1:0]       wr_addr;
  logic [IW-1:0]       rd_addr;
  logic                rd_ok;

  logic [DATA_W-1:0]   mem [DEPTH];
  logic [DATA_W-1:0]   rdata;
  status_t             res_status;
  logic                res_ok;
  logic                res_empty;
  logic                res_full;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd <= req;
    end
  end

  always_comb begin
    front_next = front;
    rear_next  = rear;
    empty_next = empty;
    st         = ST_DONE;
    wr_en      = 1'b0;
    wr_addr    = front;
    rd_addr    = (cmd.mode == MODE_DEL_FRONT) ? front : rear;
    rd_ok      = 1'b0;
    unique case (cmd.mode)
      MODE_INS_FRONT, MODE_INS_REAR: begin
        if (empty) begin
          // first element always lands in slot zero
          front_next = '0;
          rear_next  = '0;
          empty_next = 1'b0;
          wr_en      = 1'b1;
          wr_addr    = '0;
        end else if (cmd.mode == MODE_INS_FRONT) begin
          if (front == '0) begin
            st = ST_OVERFLOW;
          end else begin
            front_next = front - IW'(1);
            wr_en      = 1'b1;
            wr_addr    = front - IW'(1);
          end
        end else begin
          if (rear == LAST) begin
            st = ST_OVERFLOW;
          end else begin
            rear_next = rear + IW'(1);
            wr_en     = 1'b1;
            wr_addr   = rear + IW'(1);
          end
        end
      end
      MODE_DEL_FRONT, MODE_DEL_REAR: begin
        if (empty) begin
          st = ST_UNDERFLOW;
        end else begin
          rd_ok = 1'b1;
          if (front == rear) begin
            front_next = '0;
            rear_next  = '0;
            empty_next = 1'b1;
          end else if (cmd.mode == MODE_DEL_FRONT) begin
            front_next = front + IW'(1);
          end else begin
            rear_next = rear - IW'(1);
          end
        end
      end
      default: begin
        st = ST_DONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      rear  <= '0;
      empty <= 1'b1;
    end else if (ctl.exec) begin
      front <= front_next;
      rear  <= rear_next;
      empty <= empty_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      res_status <= st;
      res_ok     <= rd_ok;
      res_empty  <= empty_next;
      res_full   <= !empty_next && (front_next == '0) && (rear_next == LAST);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.exec && wr_en) begin
      mem[wr_addr] <= cmd.value;
    end
    if (ctl.exec) begin
      rdata <= mem[rd_addr];
    end
  end

  assign rsp.status        = res_status;
  assign rsp.removed_value = res_ok ? rdata : '0;
  assign rsp.is_empty      = res_empty;
  assign rsp.is_full       = res_full;

  a_empty_indices: assert property (@(posedge clk) disable iff (rst)
    empty |-> (front == '0) && (rear == '0))
    else $error("indices not parked while deque empty");

  a_order: assert property (@(posedge clk) disable iff (rst)
    !empty |-> front <= rear)
    else $error("front index passed rear index");

endmodule

// ----- tb/linear_array_deque_chk.sv -----
// checker for the linear array deque: predicts each operation and compares results
module linear_array_deque_chk #(
  parameter int DEPTH = lad_pkg::DEPTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          busy,
  input  lad_pkg::req_t req,
  input  logic          done,
  input  lad_pkg::rsp_t rsp,
  output int            fail_count,
  output int            outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  import lad_pkg::*;

  logic [DATA_W-1:0] slots [DEPTH];
  int                head_idx;
  int                tail_idx;
  bit                dq_empty = 1'b1;
  rsp_t              pending_rsp [$];

  // applies one operation to the shadow deque and returns what the block should answer
  function automatic rsp_t deque_apply(req_t item);
    rsp_t r;
    r = '0;
    r.status = ST_DONE;
    if (item.mode == MODE_INS_FRONT || item.mode == MODE_INS_REAR) begin
      if (dq_empty) begin
        // first insert lands in slot 0 from either end
        head_idx = 0;
        tail_idx = 0;
        dq_empty = 1'b0;
        slots[0] = item.value;
      end else if (item.mode == MODE_INS_FRONT) begin
        if (head_idx == 0) begin
          r.status = ST_OVERFLOW;
        end else begin
          head_idx--;
          slots[head_idx] = item.value;
        end
      end else begin
        if (tail_idx == DEPTH - 1) begin
          r.status = ST_OVERFLOW;
        end else begin
          tail_idx++;
          slots[tail_idx] = item.value;
        end
      end
    end else begin
      if (dq_empty) begin
        r.status = ST_UNDERFLOW;
      end else begin
        r.removed_value = slots[item.mode == MODE_DEL_FRONT ? head_idx : tail_idx];
        if (head_idx == tail_idx) begin
          dq_empty = 1'b1;
          head_idx = 0;
          tail_idx = 0;
        end else if (item.mode == MODE_DEL_FRONT) begin
          head_idx++;
        end else begin
          tail_idx--;
        end
      end
    end
    r.is_empty = dq_empty;
    r.is_full = !dq_empty && head_idx == 0 && tail_idx == DEPTH - 1;
    return r;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    int   errs;
    errs = 0;
    if (!rst) begin
      // results first, so a transfer at the same edge cannot be matched to itself
      if (done === 1'b1) begin
        if (pending_rsp.size() == 0) begin
          $error("result with no operation outstanding");
          errs++;
        end else begin
          want = pending_rsp.pop_front();
          if (rsp.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp.status);
            errs++;
          end
          if (rsp.removed_value !== want.removed_value) begin
            $error("removed_value: expected %0d, got %0d", want.removed_value,
                   rsp.removed_value);
            errs++;
          end
          if (rsp.is_empty !== want.is_empty) begin
            $error("is_empty: expected %0d, got %0d", want.is_empty, rsp.is_empty);
            errs++;
          end
          if (rsp.is_full !== want.is_full) begin
            $error("is_full: expected %0d, got %0d", want.is_full, rsp.is_full);
            errs++;
          end
        end
      end
      if (start && !busy) pending_rsp.push_back(deque_apply(req));
      fail_count <= fail_count + errs;
    end
    outstanding <= pending_rsp.size();
  end

endmodule

// ----- tb/tb.sv -----
// testbench top: drives deque operations and reports the verdict
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lad_pkg::*;

  localparam int DEPTH = DEPTH_DEFAULT;
  localparam int RANDOM_OPS = 1980;
  localparam int QUIET_FROM = 1700;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic done;
  req_t req = '0;
  rsp_t rsp;
  int   fail_count;
  int   outstanding;
  bit   gaps_on;

  linear_array_deque_top #(.DEPTH(DEPTH)) dut (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .req  (req),
    .done (done),
    .rsp  (rsp)
  );

  linear_array_deque_chk #(.DEPTH(DEPTH)) chk (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .req        (req),
    .done       (done),
    .rsp        (rsp),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #1ms;
    $display("[linear_array_deque_top] ERROR");
    $finish;
  end

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '1;
      3: return '0;
      default: return $urandom;
    endcase
  endfunction

  // holds the operation until the block takes it
  task automatic issue_op(input mode_t m, input logic [DATA_W-1:0] v);
    req_t item;
    item.mode = m;
    item.value = v;
    start <= 1'b1;
    req <= item;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic maybe_gap();
    if (gaps_on && $urandom_range(0, 2) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic drain_wait();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    int   ins_pct;
    bit   want_ins;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: underflow both ends, lone element, fill to full, both overflows
    gaps_on = 1'b0;
    issue_op(MODE_DEL_FRONT, 32'h1234_5678);
    issue_op(MODE_DEL_REAR, 32'hffff_ffff);
    issue_op(MODE_INS_FRONT, 32'h8000_0000);
    issue_op(MODE_DEL_REAR, 32'h0);
    issue_op(MODE_INS_REAR, 32'h7fff_ffff);
    for (int i = 1; i < DEPTH; i++) issue_op(MODE_INS_REAR, (i == 1) ? '1 : i * 32'h1111_1111);
    issue_op(MODE_INS_REAR, 32'h5555_5555);
    issue_op(MODE_INS_FRONT, 32'haaaa_aaaa);
    issue_op(MODE_DEL_FRONT, 32'h0);
    issue_op(MODE_DEL_FRONT, 32'h0);
    issue_op(MODE_INS_FRONT, 32'hdead_beef);
    issue_op(MODE_DEL_REAR, 32'h0);
    issue_op(MODE_INS_REAR, 32'h0000_0001);
    issue_op(MODE_DEL_FRONT, 32'h0);
    issue_op(MODE_DEL_FRONT, 32'h0);
    drain_wait();

    // random: segments that lean toward filling, draining or neither
    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (n % 16 == 0) begin
        case ($urandom_range(0, 2))
          0: ins_pct = 80;
          1: ins_pct = 20;
          default: ins_pct = 50;
        endcase
        gaps_on = (n < QUIET_FROM) && ($urandom_range(0, 2) != 0);
      end
      if (n == RANDOM_OPS / 2) drain_wait();
      want_ins = $urandom_range(1, 100) <= ins_pct;
      if (want_ins) begin
        issue_op($urandom_range(0, 1) ? MODE_INS_REAR : MODE_INS_FRONT, pick_value());
      end else begin
        issue_op($urandom_range(0, 1) ? MODE_DEL_REAR : MODE_DEL_FRONT, pick_value());
      end
      maybe_gap();
    end

    drain_wait();
    repeat (5) @(posedge clk);
    if (fail_count == 0) begin
      $display("[linear_array_deque_top] OK");
    end else begin
      $display("[linear_array_deque_top] ERROR");
    end
    $finish;
  end

endmodule
